/* sv/twrq_pkg.sv */
// ----------------------------------------------------------------------------
// twrq_pkg
// Shared types and constants of the time window request queue.
// ----------------------------------------------------------------------------
package twrq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int TAG_W  = 16;
    localparam int TIME_W = 48;
    localparam int APP_W  = 15;   // key multiplier 32768 = 2**APP_W
    localparam int WIN_W  = 17;   // saturated window index
    localparam int KEY_W  = WIN_W + APP_W;
    localparam int SIZE_W = 32;
    localparam int STEP_W = $clog2(TIME_W);

    localparam logic [WIN_W-1:0] WINDOW_MAX = '1;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 40;

    localparam logic CFG_WIN_MODE = 1'b0;
    localparam logic CFG_WIN_SIZE = 1'b1;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_KEY,
        S_FIND,
        S_SCAN,
        S_PUT,
        S_POP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic [APP_W-1:0] app;
    } t_entry;

    localparam int ENTRY_W = KEY_W + TAG_W + APP_W;

endpackage

/* sv/twrq_ram.sv */
// ----------------------------------------------------------------------------
// twrq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module twrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/time_window_request_queue.sv */
// ----------------------------------------------------------------------------
// time_window_request_queue
// Bounded I/O request queue, FIFO or ordered by time window key.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream takes one request word; tuser selects insert (0) or pop (1).
//  - Master stream returns exactly one result word per request word.
//  - The user writes the config port (window_mode, window_size) only while the
//    queue is idle; the block itself does not enforce this.
//  - Entries sit in one RAM as a circular buffer (head pointer plus count).
//  - Insert: key = min(arrival / window_size, 131071) * 32768 + app_queue.
//    The divider is restoring, one quotient bit a cycle.
//    FIFO mode or an empty queue writes at the tail.
//    Window mode reads from the head, one entry a cycle, for the first larger
//    key, then walks back from the tail moving each entry from there up by one.
//  - Pop reads the head entry.
//  - Only one word is in work at a time; s_axis_tready is high when idle.
//  - The result sits in an output register; a stalled master only holds the
//    next result back, a new word is still taken meanwhile.
//  - Reset clears count, head, window_mode and the output valid, sets window_size
//    to 1; RAM needs no clearing as only stored entries are ever read.
// ----------------------------------------------------------------------------
module time_window_request_queue
    import twrq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // request_tag[15:0], arrival[63:16], app_queue[78:64], zero pad
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // mode
    input  logic                  i_s_axis_tuser,
    // master stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // accepted[0], full_reject[1], out_tag[17:2], out_app_queue[32:18],
    // now_empty[33], zero pad
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    // config write
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [SIZE_W-1:0]     i_cfg_data
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  r_head,  n_head;
    logic              r_win_mode;
    logic [SIZE_W-1:0] r_win_size;

    // divider
    logic [SIZE_W-1:0] r_rem,  n_rem;
    logic [TIME_W-1:0] r_quo,  n_quo;
    logic [STEP_W-1:0] r_step, n_step;

    // request being inserted
    logic [KEY_W-1:0]  r_key, n_key;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [APP_W-1:0]  r_app, n_app;
    logic [CNT_W-1:0]  r_j,   n_j;    // logical slot whose data is on the read port
    logic [CNT_W-1:0]  r_pos, n_pos;  // insertion slot in window mode

    // pending result
    logic              r_res_acc, n_res_acc;
    logic              r_res_rej, n_res_rej;
    logic [TAG_W-1:0]  r_res_tag, n_res_tag;
    logic [APP_W-1:0]  r_res_app, n_res_app;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    // RAM ports
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr, ram_raddr;
    t_entry           ram_wdata, ram_rdata;
    logic [ENTRY_W-1:0] ram_rbits;

    logic              s_fire;
    logic              out_free;
    logic              out_load;
    logic [SIZE_W:0]   div_sh;
    logic [SIZE_W:0]   div_diff;
    logic [WIN_W-1:0]  win_idx;
    t_entry            new_entry;

    twrq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = t_entry'(ram_rbits);

    // logical slot to RAM address, head + slot wraps once at most
    function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                              input logic [CNT_W-1:0] slot);
        logic [PTR_W:0] s;
        s = {1'b0, head} + (PTR_W+1)'(slot);
        if (s >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            s = s - (PTR_W+1)'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_m_valid || i_m_axis_tready;
    assign out_load        = (r_state == S_DONE) && out_free;

    // one restoring step
    assign div_sh   = {r_rem, r_quo[TIME_W-1]};
    assign div_diff = div_sh - {1'b0, r_win_size};

    // saturate; a zero divisor gives all ones here as well
    assign win_idx = (r_quo[TIME_W-1:WIN_W] != '0) ? WINDOW_MAX : r_quo[WIN_W-1:0];

    assign new_entry = '{key: r_key, tag: r_tag, app: r_app};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_head    = r_head;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_step    = r_step;
        n_key     = r_key;
        n_tag     = r_tag;
        n_app     = r_app;
        n_j       = r_j;
        n_pos     = r_pos;
        n_res_acc = r_res_acc;
        n_res_rej = r_res_rej;
        n_res_tag = r_res_tag;
        n_res_app = r_res_app;
        ram_we    = 1'b0;
        ram_waddr = phys(r_head, r_count);
        ram_wdata = new_entry;
        ram_raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_res_acc = 1'b0;
                    n_res_rej = 1'b0;
                    n_res_tag = '0;
                    n_res_app = '0;
                    n_tag     = i_s_axis_tdata[15:0];
                    n_app     = i_s_axis_tdata[78:64];
                    if (i_s_axis_tuser == MODE_POP) begin
                        n_state = (r_count == '0) ? S_DONE : S_POP;
                    end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                        n_res_rej = 1'b1;
                        n_state   = S_DONE;
                    end else begin
                        n_rem   = '0;
                        n_quo   = i_s_axis_tdata[63:16];
                        n_step  = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (!div_diff[SIZE_W]) begin
                    n_rem = div_diff[SIZE_W-1:0];
                    n_quo = {r_quo[TIME_W-2:0], 1'b1};
                end else begin
                    n_rem = div_sh[SIZE_W-1:0];
                    n_quo = {r_quo[TIME_W-2:0], 1'b0};
                end
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(TIME_W - 1)) begin
                    n_state = S_KEY;
                end
            end
            S_KEY: begin
                n_key = {win_idx, r_app};
                if (!r_win_mode || r_count == '0) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{key: {win_idx, r_app}, tag: r_tag, app: r_app};
                    n_count   = r_count + 1'b1;
                    n_res_acc = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    ram_raddr = r_head;
                    n_j       = '0;
                    n_state   = S_FIND;
                end
            end
            S_FIND: begin
                // entry r_j is on the read port; stop at the first larger key
                if (ram_rdata.key > r_key) begin
                    n_pos     = r_j;
                    ram_raddr = phys(r_head, r_count - 1'b1);
                    n_j       = r_count - 1'b1;
                    n_state   = S_SCAN;
                end else if (r_j == r_count - 1'b1) begin
                    // no larger key: append at the tail
                    ram_we    = 1'b1;
                    n_count   = r_count + 1'b1;
                    n_res_acc = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    ram_raddr = phys(r_head, r_j + 1'b1);
                    n_j       = r_j + 1'b1;
                end
            end
            S_SCAN: begin
                // entry r_j is on the read port; move it up one slot
                ram_we    = 1'b1;
                ram_waddr = phys(r_head, r_j + 1'b1);
                ram_wdata = ram_rdata;
                ram_raddr = phys(r_head, r_j - 1'b1);
                n_j       = r_j - 1'b1;
                if (r_j == r_pos) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = phys(r_head, r_pos);
                n_count   = r_count + 1'b1;
                n_res_acc = 1'b1;
                n_state   = S_DONE;
            end
            S_POP: begin
                n_res_acc = 1'b1;
                n_res_tag = ram_rdata.tag;
                n_res_app = ram_rdata.app;
                n_count   = r_count - 1'b1;
                n_head    = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_head     <= '0;
            r_win_mode <= 1'b0;
            r_win_size <= SIZE_W'(1);
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIN_MODE: r_win_mode <= i_cfg_data[0];
                    CFG_WIN_SIZE: r_win_size <= i_cfg_data;
                    default:      r_win_size <= r_win_size;
                endcase
            end
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_step    <= n_step;
        r_key     <= n_key;
        r_tag     <= n_tag;
        r_app     <= n_app;
        r_j       <= n_j;
        r_pos     <= n_pos;
        r_res_acc <= n_res_acc;
        r_res_rej <= n_res_rej;
        r_res_tag <= n_res_tag;
        r_res_app <= n_res_app;
        if (out_load) begin
            r_m_data <= {6'b0, (r_count == '0), r_res_app, r_res_tag,
                         r_res_rej, r_res_acc};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_count != '0)
        else $error("ordered walk on an empty queue");

    a_reject_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && r_res_rej |-> r_count == CNT_W'(QUEUE_DEPTH) && !r_res_acc)
        else $error("reject issued with room in the queue");

    a_pop_moves_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |=> r_head != $past(r_head) || QUEUE_DEPTH == 1)
        else $error("pop left the head pointer unchanged");

endmodule
